FILE: sv/calendar_date_up_down_counter_defines.svh
// Assertion macros shared by the calendar date counter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CALENDAR_DATE_UP_DOWN_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_UP_DOWN_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date counter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date counter: next-cycle check failed");

`endif

FILE: sv/cdc_pkg.sv
// Types, codes and calendar helper functions for the date counter.
// No dependencies; imported by cdc_step, calendar_date_up_down_counter and the testbench.
package cdc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_DEC     = 5'd31;

    // floor(y * 5243 / 2^19) == floor(y / 100) for every 14-bit year
    localparam logic [12:0] HUNDRED_RECIP = 13'd5243;
    localparam int          HUNDRED_SHIFT = 19;
    localparam int          PROD_W        = YEAR_W + 13;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_INC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_CMP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LIMIT   = 2'd2
    } status_t;

    localparam logic signed [1:0] ORD_LESS    = -2'sd1;
    localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
    localparam logic signed [1:0] ORD_GREATER = 2'sd1;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        op_t   op;
        date_t date;
        logic  leap;
    } item_t;

    typedef struct packed {
        date_t             date;
        status_t           status;
        logic signed [1:0] order;
    } step_res_t;

    // Gregorian leap rule without a divider
    function automatic logic leap_of(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [7:0]        q;
        logic [YEAR_W:0]   hund;
        prod = PROD_W'(y) * PROD_W'(HUNDRED_RECIP);
        q    = prod[HUNDRED_SHIFT +: 8];
        hund = ((YEAR_W+1)'(q) << 6) + ((YEAR_W+1)'(q) << 5) + ((YEAR_W+1)'(q) << 2);
        return (y[1:0] == 2'd0) && ((hund != {1'b0, y}) || (q[1:0] == 2'd0));
    endfunction

    // Month length; months outside the calendar count as 31 days
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: sv/calendar_date_up_down_counter.sv
// Gregorian date up/down counter top level: input register, date state, result register.
// Depends on cdc_pkg, cdc_step and calendar_date_up_down_counter_defines.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_ready  | operation, in_year, in_month, in_day
//  out     | out_valid / out_ready| cur_year, cur_month, cur_day, status, order, leap_year
//
// An accepted item is held in the input register; when the result register is empty or being
// drained, the next edge runs it through the date update into the result register, so while
// out_ready stays high one item per cycle is sustained.
// The date itself is the state register and changes only when a result is loaded, so
// it stays put while a result is stalled. Reset gives 0000-01-01 with both stages empty.
// The input register takes a new item while a result waits, then input stalls too.
`include "calendar_date_up_down_counter_defines.svh"
module calendar_date_up_down_counter
    import cdc_pkg::*;
#(
    parameter int YEAR_LIMIT = 9999
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [YEAR_W-1:0]   in_year,
    input  logic [MONTH_W-1:0]  in_month,
    input  logic [DAY_W-1:0]    in_day,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [YEAR_W-1:0]   cur_year,
    output logic [MONTH_W-1:0]  cur_month,
    output logic [DAY_W-1:0]    cur_day,
    output logic [1:0]          status,
    output logic signed [1:0]   order,
    output logic                leap_year
);

    localparam logic [YEAR_W-1:0] LIMIT_Y = YEAR_W'(YEAR_LIMIT);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    item_t             s1_item_reg;
    item_t             s1_item_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic signed [1:0] order_reg;
    logic signed [1:0] order_next;
    date_t             date_reg;
    date_t             date_next;
    logic              cur_leap;
    logic              in_take;
    logic              advance;
    step_res_t         res;

    // Handshake: the result stage moves when it is empty or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Capture the item and its leap flag
    always_comb
    begin
        s1_valid_next          = in_take || (s1_valid_reg && !advance);
        s1_item_next.op        = op_t'(operation);
        s1_item_next.date      = '{year: in_year, month: in_month, day: in_day};
        s1_item_next.leap      = leap_of(in_year);
    end

    assign cur_leap = leap_of(date_reg.year);

    cdc_step #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_step (
        .item     (s1_item_reg),
        .cur      (date_reg),
        .cur_leap (cur_leap),
        .res      (res)
    );

    // Select next date and result
    always_comb
    begin
        out_valid_next = advance || (out_valid_reg && !out_ready);
        date_next      = advance ? res.date   : date_reg;
        status_next    = advance ? res.status : status_reg;
        order_next     = advance ? res.order  : order_reg;
    end

    // Hold control state and the date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            date_reg      <= '{year: '0, month: MONTH_FIRST, day: DAY_FIRST};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            date_reg      <= date_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg <= '0;
            status_reg  <= ST_OK;
            order_reg   <= ORD_EQUAL;
        end
        else
        begin
            if (in_take)
            begin
                s1_item_reg <= s1_item_next;
            end
            status_reg <= status_next;
            order_reg  <= order_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cur_year  = date_reg.year;
    assign cur_month = date_reg.month;
    assign cur_day   = date_reg.day;
    assign status    = status_reg;
    assign order     = order_reg;
    assign leap_year = cur_leap;

    // Stored date is always a real calendar date within range
    `CDC_ASSERT_IMP(a_date_valid, clk, rst_n, 1'b1,
        (date_reg.year <= LIMIT_Y) && (date_reg.month >= MONTH_FIRST)
        && (date_reg.month <= MONTH_LAST) && (date_reg.day >= DAY_FIRST)
        && (date_reg.day <= month_len(cur_leap, date_reg.month)))
    // A stalled result keeps its date
    `CDC_ASSERT_NXT(a_stall_date, clk, rst_n, out_valid_reg && !out_ready,
        date_reg == $past(date_reg))
    // A rejected or limited item leaves the date untouched
    `CDC_ASSERT_NXT(a_reject_hold, clk, rst_n, advance && (res.status != ST_OK),
        date_reg == $past(date_reg))
    // An ordering result only comes with an ok status
    `CDC_ASSERT_IMP(a_order_ok, clk, rst_n, out_valid_reg && (order_reg != ORD_EQUAL),
        status_reg == ST_OK)

endmodule

FILE: sv/cdc_step.sv
// Date update for one item: load, step forward, step back or compare.
// Depends on cdc_pkg; purely combinational, used by the top level.
module cdc_step
    import cdc_pkg::*;
#(
    parameter int YEAR_LIMIT = 9999
)
(
    input  item_t     item,
    input  date_t     cur,
    input  logic      cur_leap,
    output step_res_t res
);

    localparam logic [YEAR_W-1:0] LIMIT_Y = YEAR_W'(YEAR_LIMIT);

    logic [KEY_W-1:0]   cur_key;
    logic [KEY_W-1:0]   in_key;
    logic [DAY_W-1:0]   cur_len;
    logic [DAY_W-1:0]   in_len;
    logic [DAY_W-1:0]   prev_len;
    logic [MONTH_W-1:0] prev_month;
    logic               in_ok;
    logic               at_top;
    logic               at_bottom;

    // Compare keys and month lengths
    always_comb
    begin
        cur_key    = {cur.year, cur.month, cur.day};
        in_key     = {item.date.year, item.date.month, item.date.day};
        cur_len    = month_len(cur_leap, cur.month);
        in_len     = month_len(item.leap, item.date.month);
        prev_month = cur.month - MONTH_FIRST;
        prev_len   = month_len(cur_leap, prev_month);
        in_ok      = (item.date.year <= LIMIT_Y)
                     && (item.date.month >= MONTH_FIRST) && (item.date.month <= MONTH_LAST)
                     && (item.date.day >= DAY_FIRST) && (item.date.day <= in_len);
        at_top     = cur_key >= {LIMIT_Y, MONTH_LAST, DAY_DEC};
        at_bottom  = cur_key <= {{YEAR_W{1'b0}}, MONTH_FIRST, DAY_FIRST};
    end

    // Apply the operation
    always_comb
    begin
        res.date   = cur;
        res.status = ST_OK;
        res.order  = ORD_EQUAL;
        unique case (item.op)
            OP_LOAD:
            begin
                if (in_ok)
                begin
                    res.date = item.date;
                end
                else
                begin
                    res.status = ST_INVALID;
                end
            end
            OP_INC:
            begin
                if (at_top)
                begin
                    res.status = ST_LIMIT;
                end
                else if (cur.day < cur_len)
                begin
                    res.date.day = cur.day + DAY_FIRST;
                end
                else
                begin
                    res.date.day = DAY_FIRST;
                    if (cur.month < MONTH_LAST)
                    begin
                        res.date.month = cur.month + MONTH_FIRST;
                    end
                    else
                    begin
                        res.date.month = MONTH_FIRST;
                        res.date.year  = cur.year + YEAR_W'(1);
                    end
                end
            end
            OP_DEC:
            begin
                if (at_bottom)
                begin
                    res.status = ST_LIMIT;
                end
                else if (cur.day > DAY_FIRST)
                begin
                    res.date.day = cur.day - DAY_FIRST;
                end
                else if (cur.month > MONTH_FIRST)
                begin
                    res.date.month = prev_month;
                    res.date.day   = prev_len;
                end
                else
                begin
                    // December is 31 days in every year
                    res.date.month = MONTH_LAST;
                    res.date.day   = DAY_DEC;
                    res.date.year  = cur.year - YEAR_W'(1);
                end
            end
            OP_CMP:
            begin
                if (!in_ok)
                begin
                    res.status = ST_INVALID;
                end
                else if (cur_key > in_key)
                begin
                    res.order = ORD_GREATER;
                end
                else if (cur_key < in_key)
                begin
                    res.order = ORD_LESS;
                end
                else
                begin
                    res.order = ORD_EQUAL;
                end
            end
        endcase
    end

endmodule

FILE: tb/sv/calendar_date_up_down_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_up_down_counter: directed table, then random items.
// Depends on cdc_pkg and the calendar_date_up_down_counter RTL; expected dates come from a
// calendar predictor kept inside this file.
module calendar_date_up_down_counter_tb;
    import cdc_pkg::*;

    localparam int LAST_YEAR      = 9999;
    localparam int DIRECTED_COUNT = 26;
    localparam int RANDOM_ITEMS   = 1080;
    localparam int STALL_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        status_t            status;
        logic signed [1:0]  order;
        logic               leap;
    } date_result_t;

    typedef struct packed {
        op_t                op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               typed;
        date_result_t       res;
    } date_row_t;

    localparam date_result_t NO_TYPED = '{14'd0, 4'd0, 5'd0, ST_OK, ORD_EQUAL, 1'b0};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    op_t                operation;
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [1:0]         status;
    logic signed [1:0]  order;
    logic               leap_year;

    // Hand-typed expectation traveling with the item being driven
    logic               row_typed;
    date_result_t       row_result;

    // Predicted calendar state, advanced on every accepted item
    int held_year  = 0;
    int held_month = 1;
    int held_day   = 1;

    date_result_t date_results_due[$];
    date_row_t    directed_rows[DIRECTED_COUNT];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           ready_hold  = 0;
    logic         calm = 1'b0;

    calendar_date_up_down_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .in_year   (in_year),
        .in_month  (in_month),
        .in_day    (in_day),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cur_year  (cur_year),
        .cur_month (cur_month),
        .cur_day   (cur_day),
        .status    (status),
        .order     (order),
        .leap_year (leap_year)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int days_of_month(input int y, input int m);
        int len;
        case (m)
            2:            len = is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  len = 30;
            default:      len = 31;
        endcase
        return len;
    endfunction

    function automatic logic date_is_valid(input int y, input int m, input int d);
        return y <= LAST_YEAR && m >= 1 && m <= 12 && d >= 1 && d <= days_of_month(y, m);
    endfunction

    // Sign of held date minus given date
    function automatic int date_order(input int y, input int m, input int d);
        int sgn;
        if (held_year != y)
            sgn = (held_year > y) ? 1 : -1;
        else if (held_month != m)
            sgn = (held_month > m) ? 1 : -1;
        else if (held_day != d)
            sgn = (held_day > d) ? 1 : -1;
        else
            sgn = 0;
        return sgn;
    endfunction

    // Valid date biased toward leap years, century years and month and year ends
    function automatic date_t random_valid_date();
        date_t dt;
        int    y;
        int    m;
        int    len;
        if ($urandom_range(0, 9) < 4)
        begin
            y = $urandom_range(0, LAST_YEAR);
            m = $urandom_range(1, 12);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       y = 0;
                1:       y = 1;
                2:       y = 99;
                3:       y = 100;
                4:       y = 400;
                5:       y = 1900;
                6:       y = 2000;
                7:       y = 2024;
                8:       y = 9998;
                default: y = LAST_YEAR;
            endcase
            case ($urandom_range(0, 3))
                0:       m = 1;
                1:       m = 2;
                2:       m = 12;
                default: m = $urandom_range(1, 12);
            endcase
        end
        len = days_of_month(y, m);
        dt.year  = YEAR_W'(y);
        dt.month = MONTH_W'(m);
        case ($urandom_range(0, 3))
            0:       dt.day = DAY_W'(1);
            1:       dt.day = DAY_W'(len);
            2:       dt.day = DAY_W'(len - 1);
            default: dt.day = DAY_W'($urandom_range(1, len));
        endcase
        return dt;
    endfunction

    // Apply one operation to the held date and return the result it produces
    task automatic advance_calendar(input op_t op, input int y, input int m, input int d,
                                    output date_result_t r);
        status_t           st;
        logic signed [1:0] ord;
        st  = ST_OK;
        ord = ORD_EQUAL;
        case (op)
            OP_LOAD:
            begin
                if (date_is_valid(y, m, d))
                begin
                    held_year  = y;
                    held_month = m;
                    held_day   = d;
                end
                else
                    st = ST_INVALID;
            end
            OP_INC:
            begin
                if (date_order(LAST_YEAR, 12, 31) >= 0)
                    st = ST_LIMIT;
                else if (held_day < days_of_month(held_year, held_month))
                    held_day++;
                else
                begin
                    held_day = 1;
                    if (held_month < 12)
                        held_month++;
                    else
                    begin
                        held_month = 1;
                        held_year++;
                    end
                end
            end
            OP_DEC:
            begin
                if (date_order(0, 1, 1) <= 0)
                    st = ST_LIMIT;
                else if (held_day > 1)
                    held_day--;
                else
                begin
                    if (held_month > 1)
                        held_month--;
                    else
                    begin
                        held_month = 12;
                        held_year--;
                    end
                    held_day = days_of_month(held_year, held_month);
                end
            end
            default:
            begin
                if (!date_is_valid(y, m, d))
                    st = ST_INVALID;
                else
                begin
                    case (date_order(y, m, d))
                        1:       ord = ORD_GREATER;
                        -1:      ord = ORD_LESS;
                        default: ord = ORD_EQUAL;
                    endcase
                end
            end
        endcase
        r.year   = YEAR_W'(held_year);
        r.month  = MONTH_W'(held_month);
        r.day    = DAY_W'(held_day);
        r.status = st;
        r.order  = ord;
        r.leap   = is_leap_year(held_year);
    endtask

    // Present one item, hold it until accepted, then idle for a random gap
    task automatic send_item(input op_t op, input logic [YEAR_W-1:0] y,
                             input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                             input logic typed, input date_result_t res);
        int gap;
        int r;
        in_valid   <= 1'b1;
        operation  <= op;
        in_year    <= y;
        in_month   <= m;
        in_day     <= d;
        row_typed  <= typed;
        row_result <= res;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            gap = 0;
        else if (r < 94)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drive result-side backpressure: mostly short stalls, a few long ones
    always @(negedge clk)
    begin : drive_out_ready
        int r;
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (calm)
            out_ready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 4);
            end
            else if (r < 92)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(8, 30);
            end
        end
    end

    // Check each result against the oldest pending date, then record newly accepted items
    always @(posedge clk)
    begin : check_results
        date_result_t got;
        date_result_t want;
        if (rst_n)
        begin
            if ((out_valid && out_ready) || (in_valid && in_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (out_valid && out_ready)
            begin
                got = '{cur_year, cur_month, cur_day, status_t'(status), order, leap_year};
                if (date_results_due.size() == 0)
                begin
                    if (error_count < REPORT_MAX)
                        $display("tb: unexpected result %0d-%0d-%0d status %0d",
                                 got.year, got.month, got.day, got.status);
                    error_count++;
                end
                else
                begin
                    want = date_results_due.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.status !== want.status ||
                        got.order !== want.order || got.leap !== want.leap)
                    begin
                        if (error_count < REPORT_MAX)
                        begin
                            $write("tb: mismatch exp %0d-%0d-%0d st %0d ord %0d leap %0d",
                                   want.year, want.month, want.day, want.status,
                                   want.order, want.leap);
                            $display(" got %0d-%0d-%0d st %0d ord %0d leap %0d",
                                     got.year, got.month, got.day,
                                     got.status, got.order, got.leap);
                        end
                        error_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                advance_calendar(operation, int'(in_year), int'(in_month), int'(in_day), want);
                if (row_typed)
                    want = row_result;
                date_results_due.push_back(want);
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        op_t                op;
        op_t                run_op;
        int                 run_left;
        int                 r;
        int                 i;
        date_t              dt;
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;

        directed_rows = '{
            '{OP_CMP,  14'd0,     4'd1,  5'd1,  1'b1, '{14'd0, 4'd1, 5'd1, ST_OK, ORD_EQUAL, 1'b1}},
            '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b1,
              '{14'd0, 4'd1, 5'd1, ST_LIMIT, ORD_EQUAL, 1'b1}},
            '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b0, NO_TYPED},
            '{OP_LOAD, 14'd9999,  4'd12, 5'd31, 1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_OK, ORD_EQUAL, 1'b0}},
            '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_LIMIT, ORD_EQUAL, 1'b0}},
            '{OP_CMP,  14'd9999,  4'd12, 5'd31, 1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_OK, ORD_EQUAL, 1'b0}},
            '{OP_LOAD, 14'd16383, 4'd15, 5'd31, 1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_INVALID, ORD_EQUAL, 1'b0}},
            '{OP_LOAD, 14'd10000, 4'd1,  5'd1,  1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_INVALID, ORD_EQUAL, 1'b0}},
            '{OP_LOAD, 14'd2000,  4'd0,  5'd1,  1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_INVALID, ORD_EQUAL, 1'b0}},
            '{OP_LOAD, 14'd2000,  4'd13, 5'd1,  1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_INVALID, ORD_EQUAL, 1'b0}},
            '{OP_LOAD, 14'd2000,  4'd1,  5'd0,  1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_INVALID, ORD_EQUAL, 1'b0}},
            '{OP_CMP,  14'd0,     4'd0,  5'd0,  1'b1,
              '{14'd9999, 4'd12, 5'd31, ST_INVALID, ORD_EQUAL, 1'b0}},
            '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b0, NO_TYPED},
            '{OP_LOAD, 14'd2000,  4'd2,  5'd28, 1'b1,
              '{14'd2000, 4'd2, 5'd28, ST_OK, ORD_EQUAL, 1'b1}},
            '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b0, NO_TYPED},
            '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b0, NO_TYPED},
            '{OP_LOAD, 14'd1900,  4'd2,  5'd29, 1'b0, NO_TYPED},
            '{OP_LOAD, 14'd2023,  4'd4,  5'd31, 1'b0, NO_TYPED},
            '{OP_LOAD, 14'd2024,  4'd3,  5'd1,  1'b1,
              '{14'd2024, 4'd3, 5'd1, ST_OK, ORD_EQUAL, 1'b1}},
            '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b0, NO_TYPED},
            '{OP_LOAD, 14'd1999,  4'd12, 5'd31, 1'b1,
              '{14'd1999, 4'd12, 5'd31, ST_OK, ORD_EQUAL, 1'b0}},
            '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b0, NO_TYPED},
            '{OP_CMP,  14'd2000,  4'd1,  5'd2,  1'b0, NO_TYPED},
            '{OP_CMP,  14'd1999,  4'd12, 5'd31, 1'b0, NO_TYPED},
            '{OP_LOAD, 14'd1,     4'd1,  5'd1,  1'b1,
              '{14'd1, 4'd1, 5'd1, ST_OK, ORD_EQUAL, 1'b0}},
            '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b0, NO_TYPED}
        };

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_LOAD;
        in_year    = '0;
        in_month   = '0;
        in_day     = '0;
        row_typed  = 1'b0;
        row_result = NO_TYPED;
        run_op     = OP_INC;
        run_left   = 0;

        // Hold reset, release away from the sampling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (i = 0; i < DIRECTED_COUNT; i++)
            send_item(directed_rows[i].op, directed_rows[i].year, directed_rows[i].month,
                      directed_rows[i].day, directed_rows[i].typed, directed_rows[i].res);

        // Random part: step runs, valid loads and compares, with some malformed dates
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm <= ((i % 250) < 50);
            y = YEAR_W'($urandom_range(0, 16383));
            m = MONTH_W'($urandom_range(0, 15));
            d = DAY_W'($urandom_range(0, 31));
            if (run_left > 0)
            begin
                op = run_op;
                run_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    run_op   = ($urandom_range(0, 1) == 1) ? OP_INC : OP_DEC;
                    run_left = $urandom_range(0, 39);
                    op       = run_op;
                end
                else if (r < 45)
                begin
                    op = OP_LOAD;
                    dt = random_valid_date();
                    y  = dt.year;
                    m  = dt.month;
                    d  = dt.day;
                end
                else if (r < 55)
                    op = (r < 50) ? OP_LOAD : OP_CMP;
                else if (r < 70)
                    op = OP_INC;
                else if (r < 85)
                    op = OP_DEC;
                else
                begin
                    op = OP_CMP;
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            y = YEAR_W'(held_year);
                            m = MONTH_W'(held_month);
                            d = DAY_W'(held_day);
                        end
                        1:
                        begin
                            y = YEAR_W'(held_year);
                            m = MONTH_W'(held_month);
                            d = DAY_W'($urandom_range(1, days_of_month(held_year, held_month)));
                        end
                        default:
                        begin
                            dt = random_valid_date();
                            y  = dt.year;
                            m  = dt.month;
                            d  = dt.day;
                        end
                    endcase
                end
            end
            send_item(op, y, m, d, 1'b0, NO_TYPED);
        end
        in_valid <= 1'b0;

        // Drain pending results, then keep watching for strays
        while (date_results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
